/* design/line_follow_pd_steering_core_defines.svh */
// Assertion helpers shared by the steering core RTL.
`ifndef LINE_FOLLOW_PD_STEERING_CORE_DEFINES_SVH
`define LINE_FOLLOW_PD_STEERING_CORE_DEFINES_SVH

// Condition must hold at every rising clock edge outside reset.
`define LFPS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent on the same edge.
`define LFPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

/* design/lfps_pkg.sv */
`default_nettype none
package lfps_pkg;
   localparam int SAMPLE_BITS           = 12;
   localparam int LOST_LIMIT            = 3;
   localparam int SEARCH_TICKS          = 150;
   localparam int SEARCH_PHASE_TICKS    = 25;
   localparam int STRAIGHT_COAST_LIMIT  = 10;
   localparam int ALL_BLACK_COAST_LIMIT = 5;

   localparam int KP_SMALL     = 28;
   localparam int KP_MID       = 20;
   localparam int KP_LARGE     = 14;
   localparam int BRAKE_MAX12  = 96;
   localparam int RATE_Q16     = 6554;
   localparam int SEARCH_STEER = 10;

   localparam int MISS_W   = 4;
   localparam int SEARCH_W = 8;
   localparam int SC_W     = 4;
   localparam int ABC_W    = 3;
   localparam int SPEED_W  = 23;

   // reciprocal constants for constant division
   localparam int PHASE_RECIP  = (1 << 16) / SEARCH_PHASE_TICKS + 1;
   localparam int DIV12_RECIP  = 2731;
   localparam int DIV100_RECIP = 167773;

   localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(65 << 16);

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_BLACK_RISE, REG_WHITE_FALL, REG_STRAIGHT_SPEED, REG_CURVE_SPEED,
      REG_STEER_LIMIT, REG_SEARCH_SPEED, REG_LEFT_BALANCE, REG_RIGHT_BALANCE
   } reg_idx_type;

   typedef struct packed {
      logic [11:0] black_rise;
      logic [11:0] white_fall;
      logic [6:0]  straight_speed;
      logic [6:0]  curve_speed;
      logic [6:0]  steer_limit;
      logic [6:0]  search_speed;
      logic [7:0]  left_balance;
      logic [7:0]  right_balance;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLASSIFY, ST_LAW, ST_MUL, ST_UPDATE, ST_SCALE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic classify;
      logic law;
      logic mul;
      logic update;
      logic scale;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;
endpackage
`default_nettype wire

/* design/lfps_csr.sv */
`default_nettype none
module lfps_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [lfps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready,
   output lfps_pkg::cfg_type                     cfg
);
   import lfps_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.black_rise     <= 12'd750;
         cfg_ff.white_fall     <= 12'd600;
         cfg_ff.straight_speed <= 7'd65;
         cfg_ff.curve_speed    <= 7'd43;
         cfg_ff.steer_limit    <= 7'd35;
         cfg_ff.search_speed   <= 7'd30;
         cfg_ff.left_balance   <= 8'd105;
         cfg_ff.right_balance  <= 8'd100;
      end else if (wr_en) begin
         unique case (idx)
            REG_BLACK_RISE:     cfg_ff.black_rise     <= pwdata[11:0];
            REG_WHITE_FALL:     cfg_ff.white_fall     <= pwdata[11:0];
            REG_STRAIGHT_SPEED: cfg_ff.straight_speed <= pwdata[6:0];
            REG_CURVE_SPEED:    cfg_ff.curve_speed    <= pwdata[6:0];
            REG_STEER_LIMIT:    cfg_ff.steer_limit    <= pwdata[6:0];
            REG_SEARCH_SPEED:   cfg_ff.search_speed   <= pwdata[6:0];
            REG_LEFT_BALANCE:   cfg_ff.left_balance   <= pwdata[7:0];
            REG_RIGHT_BALANCE:  cfg_ff.right_balance  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_BLACK_RISE:     prdata = {20'b0, cfg_ff.black_rise};
         REG_WHITE_FALL:     prdata = {20'b0, cfg_ff.white_fall};
         REG_STRAIGHT_SPEED: prdata = {25'b0, cfg_ff.straight_speed};
         REG_CURVE_SPEED:    prdata = {25'b0, cfg_ff.curve_speed};
         REG_STEER_LIMIT:    prdata = {25'b0, cfg_ff.steer_limit};
         REG_SEARCH_SPEED:   prdata = {25'b0, cfg_ff.search_speed};
         REG_LEFT_BALANCE:   prdata = {24'b0, cfg_ff.left_balance};
         REG_RIGHT_BALANCE:  prdata = {24'b0, cfg_ff.right_balance};
         default:            prdata = '0;
      endcase
   end
endmodule
`default_nettype wire

/* design/lfps_ctrl.sv */
`default_nettype none
module lfps_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire lfps_pkg::status_type status,
   output lfps_pkg::cmd_type         cmd
);
   import lfps_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in     = ST_LAW;
         end
         ST_LAW: begin
            cmd.law  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* design/lfps_dp.sv */
`default_nettype none
module lfps_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lfps_pkg::cfg_type    cfg,
   input  wire lfps_pkg::cmd_type    cmd,
   output lfps_pkg::status_type      status,
   input  wire logic [47:0]          req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata
);
   import lfps_pkg::*;
   `include "line_follow_pd_steering_core_defines.svh"

   localparam logic signed [6:0] CHAN_WEIGHT [4] = '{7'sd18, 7'sd6, -7'sd6, -7'sd18};

   function automatic logic signed [6:0] div3(input logic signed [6:0] s);
      logic [6:0]  m;
      logic [10:0] p;
      logic [6:0]  q;
      m = s[6] ? 7'(-s) : 7'(s);
      p = 11'(m) * 11'd11;
      q = {2'b0, p[9:5]};
      return s[6] ? $signed(7'(-q)) : $signed(q);
   endfunction

   function automatic logic signed [8:0] drive(input logic signed [18:0] p);
      logic [17:0] m;
      logic [35:0] t;
      logic [11:0] q;
      logic [8:0]  r;
      m = p[18] ? 18'(-p) : 18'(p);
      t = 36'(m) * 36'(DIV100_RECIP);
      q = t[35:24];
      if (p[18]) r = (q > 12'd256) ? 9'h100 : 9'(-q);
      else       r = (q > 12'd255) ? 9'h0ff : q[8:0];
      return $signed(r);
   endfunction

   // per-request payload and tick state
   logic [SAMPLE_BITS-1:0] samp_ff [4];
   logic [3:0]             flags_ff;
   logic signed [5:0]      prev_ff, err_ff;
   logic [MISS_W-1:0]      miss_ff;
   logic [SEARCH_W-1:0]    search_ff;
   logic                   lost_ff, timed_ff, allblack_ff, search_pos_ff;
   logic [SC_W-1:0]        sc_ff;
   logic [ABC_W-1:0]       abc_ff;
   logic [SPEED_W-1:0]     speed_ff;
   logic signed [10:0]     d12_ff;
   logic [23:0]            dmag_ff;
   logic                   dneg_ff;
   logic [36:0]            qmul_ff;
   logic signed [7:0]      steer_ff;
   logic signed [18:0]     prod_l_ff, prod_r_ff;
   logic                   out_valid_ff;
   logic [36:0]            out_ff;

   // classify
   logic [3:0]          flag_n;
   logic signed [6:0]   sum12, quot;
   logic [2:0]          cnt;
   logic                coast;
   logic [MISS_W-1:0]   miss_n;
   logic [SEARCH_W-1:0] search_n;
   logic [SC_W-1:0]     sc_n;
   logic [ABC_W-1:0]    abc_n;
   logic                lost_n;
   logic signed [5:0]   err_n;
   logic [5:0]          prev_abs;

   assign prev_abs = prev_ff[5] ? 6'(-prev_ff) : 6'(prev_ff);

   always_comb begin
      flag_n = flags_ff;
      sum12  = '0;
      for (int i = 0; i < 4; i++) begin
         if (flags_ff[i]) flag_n[i] = !(samp_ff[i] < cfg.white_fall);
         else             flag_n[i] = samp_ff[i] > cfg.black_rise;
         if (flag_n[i]) sum12 = sum12 + CHAN_WEIGHT[i];
      end
      cnt = 3'($countones(flag_n));
      case (cnt)
         3'd1:    quot = sum12;
         3'd2:    quot = sum12 >>> 1;
         3'd3:    quot = div3(sum12);
         default: quot = '0;
      endcase
      miss_n   = miss_ff;
      search_n = search_ff;
      sc_n     = sc_ff;
      abc_n    = abc_ff;
      lost_n   = lost_ff;
      err_n    = prev_ff;
      coast    = 1'b0;
      if (cnt != 3'd0) begin
         miss_n   = '0;
         search_n = '0;
         sc_n     = '0;
         lost_n   = 1'b0;
         if (cnt == 3'd4) begin
            if (abc_ff < ABC_W'(ALL_BLACK_COAST_LIMIT)) begin
               abc_n = abc_ff + 1'b1;
               coast = 1'b1;
            end
         end else begin
            abc_n = '0;
         end
         if (!coast) begin
            // snap to centre when only the inner channels see the line
            if (!flag_n[0] && !flag_n[3] && (flag_n[1] || flag_n[2])) err_n = '0;
            else err_n = quot[5:0];
         end
      end else begin
         abc_n = '0;
         if (prev_abs <= 6'd4 && sc_ff < SC_W'(STRAIGHT_COAST_LIMIT)) begin
            sc_n  = sc_ff + 1'b1;
            err_n = '0;
         end else begin
            if (miss_ff < MISS_W'(LOST_LIMIT)) miss_n = miss_ff + 1'b1;
            if (miss_n >= MISS_W'(LOST_LIMIT)) lost_n = 1'b1;
         end
      end
      if (lost_n && search_n < SEARCH_W'(SEARCH_TICKS)) search_n = search_n + 1'b1;
   end

   // control law
   logic [5:0]         ae;
   logic signed [6:0]  vel;
   logic [5:0]         kp;
   logic signed [8:0]  b4, brake;
   logic signed [10:0] kterm, d12_n;
   logic [6:0]         target;
   logic signed [23:0] delta;
   logic [24:0]        pprod;

   always_comb begin
      ae    = err_ff[5] ? 6'(-err_ff) : 6'(err_ff);
      vel   = {err_ff[5], err_ff} - {prev_ff[5], prev_ff};
      kp    = (ae < 6'd6) ? 6'(KP_SMALL) : ((ae < 6'd12) ? 6'(KP_MID) : 6'(KP_LARGE));
      b4    = {vel, 2'b0};
      brake = '0;
      if (ae <= 6'd7 && ae >= 6'd2 && err_ff != 6'sd0 && prev_ff != 6'sd0 &&
          err_ff[5] == prev_ff[5] && vel != 7'sd0 && vel[6] != err_ff[5] &&
          prev_abs >= 6'd8) begin
         if (b4 > 9'(BRAKE_MAX12))       brake = 9'(BRAKE_MAX12);
         else if (b4 < -9'(BRAKE_MAX12)) brake = -9'(BRAKE_MAX12);
         else                            brake = b4;
      end
      kterm  = $signed({5'b0, kp}) * $signed({{5{err_ff[5]}}, err_ff});
      d12_n  = kterm + $signed({vel[6], vel, 3'b0}) + $signed({{2{brake[8]}}, brake});
      target = (ae >= 6'd12) ? cfg.curve_speed : cfg.straight_speed;
      delta  = $signed({1'b0, target, 16'b0}) - $signed({1'b0, speed_ff});
      pprod  = 25'(search_ff) * 25'(PHASE_RECIP);
   end

   // steer magnitude from the sum in twelfths
   logic [10:0] d12_abs;
   logic [21:0] sprod;
   logic [6:0]  smag;
   logic [36:0] qround;
   logic [7:0]  base;
   logic [23:0] base_sum;
   logic signed [9:0] lx, rx, sdir;

   always_comb begin
      d12_abs  = d12_ff[10] ? 11'(-d12_ff) : 11'(d12_ff);
      sprod    = 22'(d12_abs) * 22'(DIV12_RECIP);
      smag     = (sprod[21:15] > cfg.steer_limit) ? cfg.steer_limit : sprod[21:15];
      qround   = qmul_ff + 37'd32768;
      base_sum = 24'(speed_ff) + 24'd32768;
      base     = base_sum[23:16];
      sdir     = search_pos_ff ? 10'(SEARCH_STEER) : -10'(SEARCH_STEER);
      if (lost_ff) begin
         lx = $signed({3'b0, cfg.search_speed}) + sdir;
         rx = $signed({3'b0, cfg.search_speed}) - sdir;
      end else begin
         lx = $signed({2'b0, base}) + $signed({{2{steer_ff[7]}}, steer_ff});
         rx = $signed({2'b0, base}) - $signed({{2{steer_ff[7]}}, steer_ff});
      end
   end

   logic signed [8:0] left_n, right_n;
   assign left_n  = timed_ff ? 9'sd0 : drive(prod_l_ff);
   assign right_n = timed_ff ? 9'sd0 : drive(prod_r_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         samp_ff[0] <= req_tdata[11:0];
         samp_ff[1] <= req_tdata[23:12];
         samp_ff[2] <= req_tdata[35:24];
         samp_ff[3] <= req_tdata[47:36];
      end
      if (cmd.law) begin
         d12_ff        <= d12_n;
         dmag_ff       <= delta[23] ? 24'(-delta) : 24'(delta);
         dneg_ff       <= delta[23];
         search_pos_ff <= (!pprod[16]) == (!prev_ff[5]);
      end
      if (cmd.mul) begin
         qmul_ff  <= 37'(dmag_ff) * 37'(RATE_Q16);
         steer_ff <= d12_ff[10] ? 8'(-{1'b0, smag}) : {1'b0, smag};
      end
      if (cmd.scale) begin
         prod_l_ff <= $signed({{9{lx[9]}}, lx}) * $signed({11'b0, cfg.left_balance});
         prod_r_ff <= $signed({{9{rx[9]}}, rx}) * $signed({11'b0, cfg.right_balance});
      end
      if (cmd.emit) begin
         out_ff <= {search_ff, miss_ff[1:0], allblack_ff, timed_ff, lost_ff,
                    err_ff, right_n, left_n};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         prev_ff      <= '0;
         err_ff       <= '0;
         miss_ff      <= '0;
         search_ff    <= '0;
         lost_ff      <= 1'b0;
         timed_ff     <= 1'b0;
         allblack_ff  <= 1'b0;
         sc_ff        <= '0;
         abc_ff       <= '0;
         speed_ff     <= SPEED_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.classify) begin
            flags_ff    <= flag_n;
            miss_ff     <= miss_n;
            search_ff   <= search_n;
            lost_ff     <= lost_n;
            sc_ff       <= sc_n;
            abc_ff      <= abc_n;
            err_ff      <= err_n;
            allblack_ff <= (cnt == 3'd4);
            timed_ff    <= lost_n && (search_n >= SEARCH_W'(SEARCH_TICKS));
         end
         if (cmd.law && !lost_ff) prev_ff <= err_ff;
         if (cmd.update && !lost_ff) begin
            speed_ff <= dneg_ff ? speed_ff - SPEED_W'(qround[36:16])
                                : speed_ff + SPEED_W'(qround[36:16]);
         end
         if (cmd.emit)      out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = {3'b0, out_ff};

   `LFPS_ASSERT_IMPLY(a_search_only_lost, clock, reset, !lost_ff, search_ff == '0)
   `LFPS_ASSERT_ALWAYS(a_search_sat, clock, reset, search_ff <= SEARCH_W'(SEARCH_TICKS))
   `LFPS_ASSERT_ALWAYS(a_miss_sat, clock, reset, miss_ff <= MISS_W'(LOST_LIMIT))
   `LFPS_ASSERT_IMPLY(a_timed_lost, clock, reset, timed_ff, lost_ff)
endmodule
`default_nettype wire

/* design/line_follow_pd_steering_core.sv */
// An accepted request walks the shared controller through six datapath steps in order
// (classify, control law, multiply, filter update, wheel scale, emit); emit waits for a
// free output register and sets rsp_tvalid. No new request is taken until the walk ends.
// The output register frees the block as soon as the result is loaded.
// Reset (synchronous, active high): registers to defaults, channels white,
// history and counters zero, smoothed speed at the default straight speed.
`default_nettype none
module line_follow_pd_steering_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: [11:0] sample_right_outer, [23:12] sample_right_inner,
   //          [35:24] sample_left_inner, [47:36] sample_left_outer
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [47:0]                      req_tdata,
   // response: [8:0] left_drive, [17:9] right_drive, [23:18] line_error,
   //           [24] line_lost, [25] search_timed_out, [26] all_black,
   //           [28:27] miss_count, [36:29] search_ticks, [39:37] zero
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [39:0]                           rsp_tdata,
   // register port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [lfps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);
   import lfps_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // register bank; the user must write it only while the block is idle (not enforced here)
   lfps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequence the datapath one step per cycle, holding in emit until the output is free
   lfps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // thresholds, error shaping, PD law, speed filter and wheel scaling
   lfps_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire

/* verif/line_follow_pd_steering_core_checker.sv */
`default_nettype none
module line_follow_pd_steering_core_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [lfps_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic        pready,
   output int               error_count,
   output int               pending,
   output int               checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import lfps_pkg::*;

   typedef struct packed {
      logic [7:0]        ticks;
      logic [1:0]        miss;
      logic              all_black;
      logic              timed_out;
      logic              lost;
      logic signed [5:0] err;
      logic signed [8:0] right;
      logic signed [8:0] left;
   } drive_type;

   drive_type drive_q[$];

   // configuration copy
   logic [11:0] rise_lvl, fall_lvl;
   logic [6:0]  straight_spd, curve_spd, steer_lim, search_spd;
   logic [7:0]  left_bal, right_bal;

   // tracker state
   logic        black[4];
   int          prev_err, older_err, miss_cnt, search_cnt, straight_cnt, blk_cnt;
   bit          lost;
   int          smooth;

   function automatic int sat9(int v);
      if (v > 255) return 255;
      if (v < -256) return -256;
      return v;
   endfunction

   function automatic int abs_i(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic drive_type steer_for(logic [47:0] d);
      int s, sum, cnt, err, base, steer, lft, rgt, ae, kp, vel, brake, lim, delta;
      longint mag, q;
      bit ab, tout, coast, even, pos;
      drive_type r;
      sum = 0; cnt = 0; tout = 0; err = 0; lft = 0; rgt = 0;
      for (int i = 0; i < 4; i++) begin
         s = d[i*12 +: 12];
         if (black[i]) begin
            if (s < fall_lvl) black[i] = 0;
         end else if (s > rise_lvl) begin
            black[i] = 1;
         end
         if (black[i]) begin
            sum += (i == 0) ? 18 : (i == 1) ? 6 : (i == 2) ? -6 : -18;
            cnt++;
         end
      end
      ab = (cnt == 4);
      if (cnt > 0) begin
         coast = 0;
         miss_cnt = 0; search_cnt = 0; straight_cnt = 0; lost = 0;
         if (cnt == 4) begin
            if (blk_cnt < ALL_BLACK_COAST_LIMIT) begin
               blk_cnt++;
               err = prev_err;
               coast = 1;
            end
         end else begin
            blk_cnt = 0;
         end
         if (!coast) begin
            // centre pair only: snap to zero
            if (!black[0] && !black[3] && (black[1] || black[2])) err = 0;
            else err = sum / cnt;
         end
      end else begin
         blk_cnt = 0;
         if (abs_i(prev_err) <= 4 && straight_cnt < STRAIGHT_COAST_LIMIT) begin
            straight_cnt++;
            err = 0;
         end else begin
            if (miss_cnt < LOST_LIMIT) miss_cnt++;
            if (miss_cnt >= LOST_LIMIT) lost = 1;
            err = prev_err;
         end
      end

      if (lost) begin
         if (search_cnt < SEARCH_TICKS) search_cnt++;
         if (search_cnt >= SEARCH_TICKS) begin
            tout = 1;
         end else begin
            even = ((search_cnt / SEARCH_PHASE_TICKS) % 2) == 0;
            pos = prev_err >= 0;
            base = search_spd;
            steer = (even == pos) ? SEARCH_STEER : -SEARCH_STEER;
            lft = (base + steer) * int'(left_bal) / 100;
            rgt = (base - steer) * int'(right_bal) / 100;
         end
      end else begin
         ae = abs_i(err);
         lim = steer_lim;
         delta = (int'(ae >= 12 ? curve_spd : straight_spd) <<< 16) - smooth;
         mag = abs_i(delta);
         q = (mag * RATE_Q16 + 32768) >>> 16;
         if (delta < 0) smooth -= int'(q);
         else smooth += int'(q);
         base = (smooth + 32768) >>> 16;
         kp = ae < 6 ? KP_SMALL : (ae < 12 ? KP_MID : KP_LARGE);
         vel = err - prev_err;
         brake = 0;
         // exit brake when swinging back towards centre from far out
         if (ae <= 7 && ae >= 2 && err * prev_err > 0 && vel * err < 0 &&
             abs_i(prev_err) >= 8) begin
            brake = 4 * vel;
            if (brake > BRAKE_MAX12) brake = BRAKE_MAX12;
            if (brake < -BRAKE_MAX12) brake = -BRAKE_MAX12;
         end
         older_err = prev_err;
         prev_err = err;
         steer = (kp * err + 8 * vel + brake) / 12;
         if (steer > lim) steer = lim;
         if (steer < -lim) steer = -lim;
         lft = (base + steer) * int'(left_bal) / 100;
         rgt = (base - steer) * int'(right_bal) / 100;
      end
      r.left = 9'(sat9(lft));
      r.right = 9'(sat9(rgt));
      r.err = 6'(err);
      r.lost = lost;
      r.timed_out = tout;
      r.all_black = ab;
      r.miss = 2'(miss_cnt);
      r.ticks = 8'(search_cnt);
      return r;
   endfunction

   function automatic void report(string field, int want, int got);
      $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      drive_type want, got;
      if (reset) begin
         rise_lvl <= 750; fall_lvl <= 600; straight_spd <= 65; curve_spd <= 43;
         steer_lim <= 35; search_spd <= 30; left_bal <= 105; right_bal <= 100;
         for (int i = 0; i < 4; i++) black[i] = 0;
         prev_err = 0; older_err = 0; miss_cnt = 0; search_cnt = 0;
         straight_cnt = 0; blk_cnt = 0; lost = 0;
         smooth = 65 << 16;
         drive_q.delete();
         error_count <= 0;
         pending <= 0;
         checked <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[4:2]))
               REG_BLACK_RISE:     rise_lvl <= pwdata[11:0];
               REG_WHITE_FALL:     fall_lvl <= pwdata[11:0];
               REG_STRAIGHT_SPEED: straight_spd <= pwdata[6:0];
               REG_CURVE_SPEED:    curve_spd <= pwdata[6:0];
               REG_STEER_LIMIT:    steer_lim <= pwdata[6:0];
               REG_SEARCH_SPEED:   search_spd <= pwdata[6:0];
               REG_LEFT_BALANCE:   left_bal <= pwdata[7:0];
               REG_RIGHT_BALANCE:  right_bal <= pwdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) drive_q.push_back(steer_for(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = drive_type'(rsp_tdata[36:0]);
            if (drive_q.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %h", $time, rsp_tdata);
               error_count <= error_count + 1;
            end else begin
               want = drive_q.pop_front();
               checked <= checked + 1;
               if (got != want) begin
                  error_count <= error_count + 1;
                  if (got.left != want.left) report("left_drive", want.left, got.left);
                  if (got.right != want.right) report("right_drive", want.right, got.right);
                  if (got.err != want.err) report("line_error", want.err, got.err);
                  if (got.lost != want.lost) report("line_lost", want.lost, got.lost);
                  if (got.timed_out != want.timed_out)
                     report("search_timed_out", want.timed_out, got.timed_out);
                  if (got.all_black != want.all_black)
                     report("all_black", want.all_black, got.all_black);
                  if (got.miss != want.miss) report("miss_count", want.miss, got.miss);
                  if (got.ticks != want.ticks) report("search_ticks", want.ticks, got.ticks);
               end
            end
         end
         pending <= drive_q.size();
      end
   end
endmodule
`default_nettype wire

/* verif/line_follow_pd_steering_core_test.sv */
`default_nettype none
module line_follow_pd_steering_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lfps_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int ITEM_TARGET = 1000;
   localparam int CALM_FROM   = 900;   // no idling from this request on
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0;
   logic [47:0] req_tdata = '0;
   logic req_tready, rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   int error_count, pending, checked;
   int sent = 0, cycles = 0;
   bit calm = 0, hold_request = 0;
   int rise_now = 750, fall_now = 600;
   int ntimeouts = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   line_follow_pd_steering_core DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   line_follow_pd_steering_core_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .error_count, .pending, .checked
   );

   // Watchdog: give up if the run stalls.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: random stall bursts, one long hold-off on request.
   initial begin
      int stall, held;
      stall = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_request && held < HOLD_CYCLES) begin
            held++;
            rsp_tready = 0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 16);
            rsp_tready = 0;
         end else begin
            rsp_tready = 1;
         end
      end
   end

   // Offer one request; gaps are taken before raising tvalid.
   task automatic send_request(logic [47:0] d);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (sent >= CALM_FROM) calm = 1;
      @(negedge clock);
   endtask

   function automatic logic [11:0] level_for(bit dark);
      if (dark) return rise_now < 4095 ? 12'($urandom_range(rise_now + 1, 4095)) : 12'hFFF;
      return fall_now > 0 ? 12'($urandom_range(0, fall_now - 1)) : 12'h000;
   endfunction

   // Build a request from a black/white mask, bit 0 = right outer channel.
   function automatic logic [47:0] line_at(logic [3:0] mask);
      logic [47:0] d;
      for (int i = 0; i < 4; i++) d[i*12 +: 12] = level_for(mask[i]);
      return d;
   endfunction

   task automatic csr_write(reg_idx_type idx, int value);
      psel = 1; penable = 0; pwrite = 1;
      paddr = CSR_ADDR_W'(int'(idx) * 4);
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
   endtask

   // Drain the block, then load a full register set.
   task automatic load_settings(int rise, int fall, int st, int cv, int lim, int srch,
                                int lb, int rb);
      req_tvalid = 0;
      while (pending != 0 || rsp_tvalid) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_write(REG_BLACK_RISE, rise);
      csr_write(REG_WHITE_FALL, fall);
      csr_write(REG_STRAIGHT_SPEED, st);
      csr_write(REG_CURVE_SPEED, cv);
      csr_write(REG_STEER_LIMIT, lim);
      csr_write(REG_SEARCH_SPEED, srch);
      csr_write(REG_LEFT_BALANCE, lb);
      csr_write(REG_RIGHT_BALANCE, rb);
      rise_now = rise;
      fall_now = fall;
   endtask

   task automatic random_settings();
      int rise;
      rise = $urandom_range(0, 4095);
      load_settings(rise, $urandom_range(0, rise), $urandom_range(0, 100),
                    $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 100),
                    $urandom_range(50, 150), $urandom_range(50, 150));
   endtask

   // One random stretch of track.
   task automatic run_segment();
      int kind, len, pos;
      logic [3:0] shapes [7];
      shapes = '{4'b0001, 4'b0011, 4'b0010, 4'b0110, 4'b0100, 4'b1100, 4'b1000};
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         // tracking: walk the line across the array
         len = $urandom_range(5, 30);
         pos = $urandom_range(0, 6);
         repeat (len) begin
            send_request(line_at($urandom_range(0, 9) == 0 ? 4'($urandom) : shapes[pos]));
            if ($urandom_range(0, 1)) pos = pos < 6 ? pos + 1 : pos;
            else pos = pos > 0 ? pos - 1 : pos;
         end
      end else if (kind <= 6) begin
         // lose the line off an edge, sometimes long enough to time out
         send_request(line_at($urandom_range(0, 1) ? 4'b0001 : 4'b1000));
         len = $urandom_range(0, 3) == 0 ? $urandom_range(155, 175) : $urandom_range(1, 12);
         if (len > 150) ntimeouts++;
         repeat (len) send_request(line_at(4'b0000));
      end else if (kind == 7) begin
         len = $urandom_range(1, 9);
         repeat (len) send_request(line_at(4'b1111));
      end else if (kind == 8) begin
         len = $urandom_range(1, 10);
         repeat (len) send_request(48'({$urandom, $urandom}));
      end else begin
         // hover around the trigger levels
         len = $urandom_range(3, 15);
         repeat (len) begin
            logic [47:0] d;
            for (int i = 0; i < 4; i++)
               d[i*12 +: 12] = 12'(($urandom_range(0, 1) ? rise_now : fall_now) +
                                   $urandom_range(0, 4) - 2);
            send_request(d);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: every channel pattern, all-black coasting past its limit, extremes
      for (int m = 0; m < 16; m++) send_request(line_at(4'(m)));
      repeat (6) send_request(line_at(4'b1111));
      send_request('0);
      send_request({48{1'b1}});

      // random: several register phases, extremes among them
      while (sent < ITEM_TARGET) begin
         case (sent * 5 / ITEM_TARGET)
            1: if (rise_now != 3000) begin
               load_settings(3000, 1000, 100, 0, 100, 100, 150, 50);
               hold_request = 1;
            end
            2: if (rise_now != 0) load_settings(0, 0, 0, 100, 0, 0, 50, 150);
            3: if (rise_now != 4095 && fall_now != 4095) begin
               load_settings(4095, 4095, 127, 127, 127, 127, 255, 255);
               repeat (5) send_request(48'({$urandom, $urandom}));
               random_settings();
            end
            4: if (!calm && fall_now != 600) load_settings(750, 600, 65, 43, 35, 30, 105, 100);
            default: ;
         endcase
         run_segment();
      end
      req_tvalid = 0;

      while (pending != 0 || rsp_tvalid) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("sent %0d sample sets, checked %0d drive results, %0d long line losses",
               sent, checked, ntimeouts);
      $display("covered five register phases including threshold and balance extremes");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
